// ===== rtl/barometer_pressure_compensation_assert.svh =====
// assertion shorthands for the pressure compensation block
`ifndef BAROMETER_PRESSURE_COMPENSATION_ASSERT_SVH
`define BAROMETER_PRESSURE_COMPENSATION_ASSERT_SVH
`ifndef SYNTHESIS
`define BPC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BPC_ASSERT_VLD(lbl, vld, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (vld) |-> (prop)) else $error(msg);
`else
`define BPC_ASSERT(lbl, prop, msg)
`define BPC_ASSERT_VLD(lbl, vld, prop, msg)
`endif
`endif

// ===== rtl/bpc_pkg.sv =====
package bpc_pkg;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_PSENS   = 3'd0,
    CFG_POFF    = 3'd1,
    CFG_TCS     = 3'd2,
    CFG_TCO     = 3'd3,
    CFG_TREF    = 3'd4,
    CFG_TSENS   = 3'd5,
    CFG_VARIANT = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic [15:0] psens;
    logic [15:0] poff;
    logic [15:0] tcs;
    logic [15:0] tco;
    logic [15:0] tref;
    logic [15:0] tsens;
    logic        variant;
  } cal_t;

  localparam int NSTG = 10;

  localparam logic signed [18:0] TEMP_BASE = 19'sd2000;
  // temp + 1500 expressed from the offset q = temp - 2000
  localparam logic signed [18:0] COLD_OFS  = 19'sd3500;

  // signed shift right that truncates toward zero
  function automatic logic signed [63:0] shr_trunc(input logic signed [63:0] x,
                                                   input int unsigned k);
    logic signed [63:0] bias;
    bias = x[63] ? ((64'sd1 <<< k) - 64'sd1) : 64'sd0;
    return (x + bias) >>> k;
  endfunction

endpackage

// ===== rtl/bpc_datapath.sv =====
`include "barometer_pressure_compensation_assert.svh"

module bpc_datapath import bpc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_vld,
  input  logic [23:0]        d1_in,
  input  logic [23:0]        d2_in,
  input  cal_t               cal,
  output logic               out_vld,
  output logic signed [31:0] p_out,
  output logic signed [18:0] t_out
);

  logic [NSTG-1:0] vld_r;

  // stage registers
  logic        [23:0] d1_1_r, d1_2_r, d1_3_r, d1_4_r, d1_5_r, d1_6_r;
  logic signed [24:0] dt_1_r;
  logic signed [41:0] pt_2_r, po_2_r, ps_2_r;
  logic signed [18:0] q_3_r;
  logic signed [18:0] t_3_r, t_4_r, t_5_r, t_6_r, t_7_r, t_8_r, t_9_r, t_10_r;
  logic signed [39:0] off_3_r, off_4_r, off_5_r;
  logic signed [39:0] sens_3_r, sens_4_r, sens_5_r;
  logic        [34:0] sqa_4_r, sqb_4_r;
  logic               cool_4_r, cold_4_r;
  logic        [37:0] off2_5_r, sens2_5_r;
  logic signed [39:0] offc_6_r, offc_7_r, offc_8_r;
  logic signed [39:0] sensc_6_r;
  logic        [43:0] lo_7_r;
  logic signed [44:0] hi_7_r;
  logic signed [42:0] q1_8_r;
  logic signed [43:0] diff_9_r;
  logic signed [31:0] p_10_r;

  // next values
  logic signed [24:0] dt_nxt;
  logic signed [16:0] c3_s, c4_s, c6_s;
  logic signed [41:0] pt_nxt, po_nxt, ps_nxt;
  logic signed [63:0] q_w, offa_w, offb_w, sensa_w, sensb_w, off_w, sens_w;
  logic signed [18:0] q_nxt, b_w;
  logic signed [37:0] sqa_w, sqb_w;
  logic        [36:0] fa_w;
  logic        [37:0] sevb_w, elevb_w, off2_nxt, sens2_nxt;
  logic signed [39:0] offc_nxt, sensc_nxt;
  logic        [43:0] lo_nxt;
  logic signed [44:0] hi_nxt;
  logic signed [63:0] prod_w, q1_w, p_w;
  logic signed [43:0] diff_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[NSTG-2:0], in_vld};
    end
  end

  // stage 1: temperature difference
  assign dt_nxt = $signed({1'b0, d2_in}) - $signed({1'b0, cal.tref, 8'h00});

  // stage 2: the three calibration products
  assign c3_s   = $signed({1'b0, cal.tcs});
  assign c4_s   = $signed({1'b0, cal.tco});
  assign c6_s   = $signed({1'b0, cal.tsens});
  assign pt_nxt = dt_1_r * c6_s;
  assign po_nxt = dt_1_r * c4_s;
  assign ps_nxt = dt_1_r * c3_s;

  // stage 3: first order temperature, offset and sensitivity
  assign q_w     = shr_trunc(64'(pt_2_r), 23);
  assign q_nxt   = q_w[18:0];
  assign offa_w  = shr_trunc(64'(po_2_r), 6);
  assign offb_w  = shr_trunc(64'(po_2_r), 7);
  assign sensa_w = shr_trunc(64'(ps_2_r), 7);
  assign sensb_w = shr_trunc(64'(ps_2_r), 8);

  always_comb begin
    if (cal.variant) begin
      off_w  = $signed({31'b0, cal.poff, 17'b0}) + offa_w;
      sens_w = $signed({32'b0, cal.psens, 16'b0}) + sensa_w;
    end else begin
      off_w  = $signed({32'b0, cal.poff, 16'b0}) + offb_w;
      sens_w = $signed({33'b0, cal.psens, 15'b0}) + sensb_w;
    end
  end

  // stage 4: squares of the distance below 20 C and below -15 C
  assign b_w   = q_3_r + COLD_OFS;
  assign sqa_w = q_3_r * q_3_r;
  assign sqb_w = b_w * b_w;

  // stage 5: second order corrections
  assign fa_w    = {sqa_4_r, 2'b00} + 37'(sqa_4_r);
  assign sevb_w  = {sqb_4_r, 3'b000} - 38'(sqb_4_r);
  assign elevb_w = {sqb_4_r, 3'b000} + 38'({sqb_4_r, 1'b0}) + 38'(sqb_4_r);

  always_comb begin
    off2_nxt  = '0;
    sens2_nxt = '0;
    if (cool_4_r) begin
      off2_nxt  = 38'(fa_w[36:1]);
      sens2_nxt = 38'(fa_w[36:2]);
    end
    if (cold_4_r) begin
      off2_nxt  = off2_nxt + sevb_w;
      sens2_nxt = sens2_nxt + 38'(elevb_w[37:1]);
    end
  end

  // stage 6: corrected offset and sensitivity
  assign offc_nxt  = off_5_r - $signed({2'b00, off2_5_r});
  assign sensc_nxt = sens_5_r - $signed({2'b00, sens2_5_r});

  // stage 7: raw pressure times sensitivity, split in two partial products
  assign lo_nxt = d1_6_r * sensc_6_r[19:0];
  assign hi_nxt = $signed({1'b0, d1_6_r}) * $signed(sensc_6_r[39:20]);

  // stage 8: recombine and scale
  assign prod_w = (64'(hi_7_r) <<< 20) + $signed({20'b0, lo_7_r});
  assign q1_w   = shr_trunc(prod_w, 21);

  // stage 9: remove offset
  assign diff_nxt = 44'(q1_8_r) - 44'(offc_8_r);

  // stage 10: final scaling
  assign p_w = shr_trunc(64'(diff_9_r), 15);

  always_ff @(posedge clk) begin
    d1_1_r    <= d1_in;
    dt_1_r    <= dt_nxt;

    d1_2_r    <= d1_1_r;
    pt_2_r    <= pt_nxt;
    po_2_r    <= po_nxt;
    ps_2_r    <= ps_nxt;

    d1_3_r    <= d1_2_r;
    q_3_r     <= q_nxt;
    t_3_r     <= q_nxt + TEMP_BASE;
    off_3_r   <= off_w[39:0];
    sens_3_r  <= sens_w[39:0];

    d1_4_r    <= d1_3_r;
    t_4_r     <= t_3_r;
    off_4_r   <= off_3_r;
    sens_4_r  <= sens_3_r;
    sqa_4_r   <= sqa_w[34:0];
    sqb_4_r   <= sqb_w[34:0];
    cool_4_r  <= q_3_r[18];
    cold_4_r  <= b_w[18];

    d1_5_r    <= d1_4_r;
    t_5_r     <= t_4_r;
    off_5_r   <= off_4_r;
    sens_5_r  <= sens_4_r;
    off2_5_r  <= off2_nxt;
    sens2_5_r <= sens2_nxt;

    d1_6_r    <= d1_5_r;
    t_6_r     <= t_5_r;
    offc_6_r  <= offc_nxt;
    sensc_6_r <= sensc_nxt;

    t_7_r     <= t_6_r;
    offc_7_r  <= offc_6_r;
    lo_7_r    <= lo_nxt;
    hi_7_r    <= hi_nxt;

    t_8_r     <= t_7_r;
    offc_8_r  <= offc_7_r;
    q1_8_r    <= q1_w[42:0];

    t_9_r     <= t_8_r;
    diff_9_r  <= diff_nxt;

    t_10_r    <= t_9_r;
    p_10_r    <= p_w[31:0];
  end

  assign out_vld = vld_r[NSTG-1];
  assign p_out   = p_10_r;
  assign t_out   = t_10_r;

  `BPC_ASSERT_VLD(a_cold_is_cool, vld_r[3] && cold_4_r, cool_4_r,
                  "below -15 C without below 20 C")
  `BPC_ASSERT_VLD(a_corr_order, vld_r[4], sens2_5_r <= off2_5_r,
                  "sensitivity correction above offset correction")
  `BPC_ASSERT_VLD(a_warm_no_corr, vld_r[4] && !$past(cool_4_r),
                  (off2_5_r == '0) && (sens2_5_r == '0), "correction applied above 20 C")

endmodule

// ===== rtl/barometer_pressure_compensation.sv =====
// second order barometric pressure compensation
//
// input channel: raw pressure and raw temperature conversions (24 bit each) are
// taken at a rising edge with start high and busy low. busy is low whenever the
// block is out of reset, so an item can be taken in every cycle.
// result channel: out_valid is high for exactly one cycle with out_pressure
// (0.01 mbar) and out_temperature (0.01 C); the receiver takes it at the edge
// that ends that cycle and has no way to hold it off.
// pipeline: an item taken with start passes through the ten register stages
// of the datapath before its result appears on the ports; a new item can be
// taken while earlier ones are in flight. throughput is one item per cycle.
// configuration: six calibration words and the variant bit are written through
// cfg_we / cfg_addr / cfg_wdata; the user writes them only while no item is in
// flight (block does not enforce it); writes past the variant index are dropped.
// reset (synchronous, active low) clears all calibration words to zero and
// empties the pipeline; items in flight are dropped and busy is high meanwhile.

`include "barometer_pressure_compensation_assert.svh"

module barometer_pressure_compensation import bpc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [23:0]        in_raw_pressure,
  input  logic [23:0]        in_raw_temperature,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_addr,
  input  logic [15:0]        cfg_wdata,
  output logic               out_valid,
  output logic signed [31:0] out_pressure,
  output logic signed [18:0] out_temperature
);

  cal_t cal_r, cal_nxt;
  logic in_take;

  always_comb begin
    cal_nxt = cal_r;
    if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_addr))
        CFG_PSENS:   cal_nxt.psens   = cfg_wdata;
        CFG_POFF:    cal_nxt.poff    = cfg_wdata;
        CFG_TCS:     cal_nxt.tcs     = cfg_wdata;
        CFG_TCO:     cal_nxt.tco     = cfg_wdata;
        CFG_TREF:    cal_nxt.tref    = cfg_wdata;
        CFG_TSENS:   cal_nxt.tsens   = cfg_wdata;
        CFG_VARIANT: cal_nxt.variant = cfg_wdata[0];
        default:     cal_nxt = cal_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_r <= '0;
    end else begin
      cal_r <= cal_nxt;
    end
  end

  assign busy    = ~rst_n;
  assign in_take = start & ~busy;

  bpc_datapath u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (in_take),
    .d1_in   (in_raw_pressure),
    .d2_in   (in_raw_temperature),
    .cal     (cal_r),
    .out_vld (out_valid),
    .p_out   (out_pressure),
    .t_out   (out_temperature)
  );

  `BPC_ASSERT(a_out_has_item, out_valid |-> $past(start && !busy, NSTG),
              "result without an item taken")
  `BPC_ASSERT_VLD(a_temp_range, out_valid,
                  (out_temperature >= -19'sd140000) && (out_temperature <= 19'sd140000),
                  "temperature out of range")

endmodule

// ===== test/barometer_pressure_compensation_tb.sv =====
module barometer_pressure_compensation_tb;
  import bpc_pkg::*;

  localparam int LATENCY = 10;
  localparam int MAX_CYCLES = 200000;
  localparam int RANDOM_PHASES = 8;
  localparam int READINGS_PER_PHASE = 112;
  localparam logic [2:0] CFG_ADDR_UNUSED = 3'd7;
  localparam logic [23:0] RAW_MAX = 24'hFFFFFF;

  localparam longint TEMP_ROOM = 2000;
  localparam longint TEMP_COLD = -1500;

  typedef struct {
    logic [23:0] raw_p;
    logic [23:0] raw_t;
  } reading_t;

  typedef struct {
    logic signed [31:0] pressure;
    logic signed [18:0] temperature;
  } compensated_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [23:0] in_raw_pressure = '0;
  logic [23:0] in_raw_temperature = '0;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_addr = '0;
  logic [15:0] cfg_wdata = '0;
  logic out_valid;
  logic signed [31:0] out_pressure;
  logic signed [18:0] out_temperature;

  reading_t pending_readings[$];
  compensated_t expected_outputs[$];
  reading_t next_reading;
  compensated_t want;
  cal_t cal_now = '0;

  int unsigned n_issued = 0;
  int unsigned n_done = 0;
  int unsigned errors = 0;
  int unsigned cycle_count = 0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;

  barometer_pressure_compensation u_top (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_raw_pressure(in_raw_pressure),
    .in_raw_temperature(in_raw_temperature),
    .cfg_we(cfg_we),
    .cfg_addr(cfg_addr),
    .cfg_wdata(cfg_wdata),
    .out_valid(out_valid),
    .out_pressure(out_pressure),
    .out_temperature(out_temperature)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // second order compensation, all terms at 64 bits, division truncating toward zero
  function automatic compensated_t compensate(input logic [23:0] raw_p,
                                              input logic [23:0] raw_t);
    longint d1, d2, c1, c2, c3, c4, c5, c6;
    longint dt, temp, off, sens, off2, sens2, sq, p;
    compensated_t r;
    d1 = {40'd0, raw_p};
    d2 = {40'd0, raw_t};
    c1 = {48'd0, cal_now.psens};
    c2 = {48'd0, cal_now.poff};
    c3 = {48'd0, cal_now.tcs};
    c4 = {48'd0, cal_now.tco};
    c5 = {48'd0, cal_now.tref};
    c6 = {48'd0, cal_now.tsens};
    dt = d2 - c5 * 256;
    if (cal_now.variant) begin
      off = c2 * 131072 + (c4 * dt) / 64;
      sens = c1 * 65536 + (c3 * dt) / 128;
    end else begin
      off = c2 * 65536 + (c4 * dt) / 128;
      sens = c1 * 32768 + (c3 * dt) / 256;
    end
    temp = TEMP_ROOM + (dt * c6) / 8388608;
    off2 = 0;
    sens2 = 0;
    if (temp < TEMP_ROOM) begin
      sq = (temp - TEMP_ROOM) * (temp - TEMP_ROOM);
      off2 = (5 * sq) / 2;
      sens2 = (5 * sq) / 4;
    end
    if (temp < TEMP_COLD) begin
      sq = (temp - TEMP_COLD) * (temp - TEMP_COLD);
      off2 += 7 * sq;
      sens2 += (11 * sq) / 2;
    end
    off -= off2;
    sens -= sens2;
    p = ((d1 * sens) / 2097152 - off) / 32768;
    r.pressure = p[31:0];
    r.temperature = temp[18:0];
    return r;
  endfunction

  function automatic logic [23:0] clamp_raw(input longint v);
    if (v < 0) return '0;
    if (v > longint'(RAW_MAX)) return RAW_MAX;
    return v[23:0];
  endfunction

  // raw temperature that lands the first-order temperature on or next to a target
  function automatic logic [23:0] raw_t_for_temp(input longint target);
    longint c5, c6, dt;
    c5 = {48'd0, cal_now.tref};
    c6 = {48'd0, cal_now.tsens};
    if (c6 == 0) dt = longint'($urandom_range(0, 2000)) - 1000;
    else dt = ((target - TEMP_ROOM) * 8388608) / c6 + longint'($urandom_range(0, 4)) - 2;
    return clamp_raw(c5 * 256 + dt);
  endfunction

  function automatic logic [15:0] pick_cal_word();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 3) return 0;
    if (sel < 9) return $urandom_range(1, 6);
    return $urandom_range(10, 30);
  endfunction

  task automatic push_reading(input logic [23:0] raw_p, input logic [23:0] raw_t);
    pending_readings.push_back('{raw_p, raw_t});
  endtask

  task automatic push_random_reading();
    logic [23:0] rp, rt;
    int unsigned sel;
    longint target;
    rp = 24'($urandom_range(0, RAW_MAX));
    rt = 24'($urandom_range(0, RAW_MAX));
    sel = $urandom_range(0, 9);
    if (sel >= 4 && sel <= 7) begin
      case ($urandom_range(0, 6))
        0: target = TEMP_ROOM - 1;
        1: target = TEMP_ROOM;
        2: target = TEMP_ROOM + 1;
        3: target = TEMP_COLD + 1;
        4: target = TEMP_COLD;
        5: target = TEMP_COLD - 1;
        default: target = longint'($urandom_range(0, 70000)) - 60000;
      endcase
      rt = raw_t_for_temp(target);
    end else if (sel == 8) begin
      rp = $urandom_range(0, 1) ? RAW_MAX : 24'd0;
      rt = $urandom_range(0, 1) ? RAW_MAX : 24'd0;
    end else if (sel == 9) begin
      rt = clamp_raw(longint'({48'd0, cal_now.tref}) * 256
                     + longint'($urandom_range(0, 2 << 20)) - (1 << 20));
    end
    push_reading(rp, rt);
  endtask

  // call right after a rising edge; the write lands on the next one
  task automatic write_cal(input logic [2:0] idx, input logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      CFG_PSENS:   cal_now.psens = val;
      CFG_POFF:    cal_now.poff = val;
      CFG_TCS:     cal_now.tcs = val;
      CFG_TCO:     cal_now.tco = val;
      CFG_TREF:    cal_now.tref = val;
      CFG_TSENS:   cal_now.tsens = val;
      CFG_VARIANT: cal_now.variant = val[0];
      default: ;
    endcase
  endtask

  task automatic drain();
    while (pending_readings.size() != 0 || n_done != n_issued) @(posedge clk);
  endtask

  task automatic flag_error(input string msg);
    errors++;
    if (errors <= 10) $display("%s", msg);
  endtask

  // sender: bursts of items separated by random gaps
  always @(posedge clk) begin
    if (start && !busy) expected_outputs.push_back(compensate(in_raw_pressure,
                                                              in_raw_temperature));
    if (rst_n && (!start || !busy)) begin
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pending_readings.size() != 0) begin
        next_reading = pending_readings.pop_front();
        n_issued++;
        start <= 1'b1;
        in_raw_pressure <= next_reading.raw_p;
        in_raw_temperature <= next_reading.raw_t;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 40);
          gap_left = pick_gap();
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_outputs.size() == 0) begin
        flag_error($sformatf("unexpected result: pressure %0d temperature %0d",
                             out_pressure, out_temperature));
      end else begin
        want = expected_outputs.pop_front();
        n_done++;
        if (out_pressure !== want.pressure || out_temperature !== want.temperature)
          flag_error($sformatf(
            "mismatch on item %0d: pressure exp %0d got %0d, temperature exp %0d got %0d",
            n_done, want.pressure, out_pressure, want.temperature, out_temperature));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= MAX_CYCLES) begin
      $display("FAIL barometer_pressure_compensation");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // calibration words still at their reset value of zero
    push_reading(24'd0, 24'd0);
    push_reading(RAW_MAX, RAW_MAX);
    push_reading(RAW_MAX, 24'd0);
    push_reading(24'd0, RAW_MAX);
    drain();

    // typical factory calibration, first variant: room, very cold, hot, exactly at dT = 0
    write_cal(CFG_PSENS, 16'd40127);
    write_cal(CFG_POFF, 16'd36924);
    write_cal(CFG_TCS, 16'd23317);
    write_cal(CFG_TCO, 16'd23282);
    write_cal(CFG_TREF, 16'd33464);
    write_cal(CFG_TSENS, 16'd28312);
    write_cal(CFG_VARIANT, 16'd0);
    cfg_we <= 1'b0;
    push_reading(24'd9085466, 24'd8569150);
    push_reading(RAW_MAX, 24'd0);
    push_reading(RAW_MAX, RAW_MAX);
    push_reading(24'd9085466, 24'd8566784);
    drain();

    // every word at its maximum, second variant
    for (int i = 0; i <= CFG_TSENS; i++) write_cal(i[2:0], 16'hFFFF);
    write_cal(CFG_VARIANT, 16'hFFFF);
    cfg_we <= 1'b0;
    push_reading(24'd0, 24'd0);
    push_reading(RAW_MAX, 24'd0);
    push_reading(RAW_MAX, RAW_MAX);
    push_reading(24'd0, RAW_MAX);
    drain();

    // upper data bits of the variant are dropped, and the unused index changes nothing
    write_cal(CFG_VARIANT, 16'hFFFE);
    write_cal(CFG_ADDR_UNUSED, 16'($urandom));
    cfg_we <= 1'b0;
    push_reading(RAW_MAX, 24'd0);
    push_reading(24'h800000, 24'h800000);
    drain();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      for (int i = 0; i <= CFG_TSENS; i++) write_cal(i[2:0], pick_cal_word());
      write_cal(CFG_VARIANT, 16'($urandom));
      cfg_we <= 1'b0;
      for (int k = 0; k < READINGS_PER_PHASE; k++) push_random_reading();
      drain();
    end

    repeat (2 * LATENCY) @(posedge clk);
    if (errors == 0 && expected_outputs.size() == 0) begin
      $display("PASS barometer_pressure_compensation");
    end else begin
      $display("FAIL barometer_pressure_compensation");
    end
    $finish;
  end

endmodule
